/* sv/tpgc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tpgc_pkg
// Key codes, widths and small types shared by the two-player game clock.
// ----------------------------------------------------------------------------
package tpgc_pkg;

    localparam int MIN_W = 7;
    localparam int SEC_W = 6;
    localparam int KEY_W = 4;

    // Key codes as seen on the keypad, widened by one bit for "no key"
    typedef logic [KEY_W:0] key_t;

    localparam key_t KEY_NONE     = 5'd16;
    localparam key_t KEY_CLR_MIN  = 5'd1;
    localparam key_t KEY_CLR_SEC  = 5'd2;
    localparam key_t KEY_PAUSE    = 5'd3;
    localparam key_t KEY_MIN_UP   = 5'd4;
    localparam key_t KEY_SEC_UP10 = 5'd5;
    localparam key_t KEY_SEC_UP1  = 5'd6;
    localparam key_t KEY_MIN_DN   = 5'd7;
    localparam key_t KEY_SEC_DN10 = 5'd8;
    localparam key_t KEY_SEC_DN1  = 5'd9;
    localparam key_t KEY_SWITCH   = 5'd10;
    localparam key_t KEY_COPY     = 5'd14;
    localparam key_t KEY_SET      = 5'd15;

    // Position in the four-digit entry sequence
    typedef enum logic [1:0] {
        DIG_MIN_TENS  = 2'd0,
        DIG_MIN_UNITS = 2'd1,
        DIG_SEC_TENS  = 2'd2,
        DIG_SEC_UNITS = 2'd3
    } digit_pos_t;

    typedef logic [MIN_W-1:0] minutes_t;
    typedef logic [SEC_W-1:0] seconds_t;

    localparam seconds_t SEC_MAX    = 6'd59;
    localparam seconds_t SEC_BORROW = 6'd60;

    // Multiply a decimal digit by ten
    function automatic logic [MIN_W-1:0] times_ten(input logic [KEY_W-1:0] d);
        logic [MIN_W-1:0] w;
        w = {{(MIN_W-KEY_W){1'b0}}, d};
        return (w << 3) + (w << 1);
    endfunction

endpackage : tpgc_pkg
`default_nettype wire

/* sv/two_player_game_clock_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_player_game_clock_unit
// Minutes and seconds for two players, driven by keypad samples and ticks.
// ----------------------------------------------------------------------------
// Each transfer on the item channel is either a keypad sample (command 0) or
// a one-second tick (command 1), and yields exactly one result with the
// active player's time and the pause and edit flags after that item. A key
// acts only when the sample differs from the previous one. The unit takes one
// item per cycle unless stalled: an item lands in an input register, and when
// it advances, the player times are updated and the result register loaded.
// Throughput is set by the single result register; it stalls only while a
// result waits on result_ready.
module two_player_game_clock_unit
    import tpgc_pkg::*;
#(
    parameter int MINUTE_LIMIT = 99
)(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire logic                command,
    input  wire logic [KEY_W-1:0]    key_code,
    input  wire logic                key_down,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output logic [MIN_W-1:0]         shown_minutes,
    output logic [SEC_W-1:0]         shown_seconds,
    output logic                     active_player,
    output logic                     paused,
    output logic                     editing
);

    localparam minutes_t MIN_LIMIT = MIN_W'(MINUTE_LIMIT);

    // Input stage
    logic             stg_valid_reg;
    logic             stg_cmd_reg;
    logic [KEY_W-1:0] stg_code_reg;
    logic             stg_down_reg;

    // Clock state
    minutes_t   min_reg   [2];
    seconds_t   sec_reg   [2];
    minutes_t   min_next  [2];
    seconds_t   sec_next  [2];
    logic       player_reg,  player_next;
    logic       pause_reg,   pause_next;
    logic       set_reg,     set_next;
    digit_pos_t dcnt_reg,    dcnt_next;
    logic [KEY_W-1:0] pend_reg, pend_next;
    key_t       prev_reg,    prev_next;

    // Result register
    logic       result_valid_reg;
    minutes_t   res_min_reg;
    seconds_t   res_sec_reg;
    logic       res_player_reg;
    logic       res_pause_reg;
    logic       res_edit_reg;

    logic       advance;

    // Working values for the active player
    logic       p;
    minutes_t   m_cur, m_new;
    seconds_t   s_cur, s_new;
    key_t       key;
    logic [MIN_W-1:0] sec_sum;
    logic [MIN_W-1:0] entry;

    assign advance    = stg_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !stg_valid_reg || advance;

    // Capture the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stg_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stg_cmd_reg  <= command;
            stg_code_reg <= key_code;
            stg_down_reg <= key_down;
        end
    end

    // Work out the next clock state from the staged item
    always_comb
    begin
        p           = player_reg;
        m_cur       = min_reg[player_reg];
        s_cur       = sec_reg[player_reg];
        m_new       = m_cur;
        s_new       = s_cur;
        key         = stg_down_reg ? {1'b0, stg_code_reg} : KEY_NONE;
        sec_sum     = '0;
        entry       = '0;
        player_next = player_reg;
        pause_next  = pause_reg;
        set_next    = set_reg;
        dcnt_next   = dcnt_reg;
        pend_next   = pend_reg;
        prev_next   = prev_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;

        if (stg_cmd_reg)
        begin
            // Tick: count down the active player unless paused or in set mode
            if (!pause_reg && !set_reg)
            begin
                if (s_cur != '0)
                begin
                    s_new = s_cur - 1'b1;
                end
                else if (m_cur != '0)
                begin
                    m_new = m_cur - 1'b1;
                    s_new = SEC_MAX;
                end
            end
        end
        else
        begin
            prev_next = key;
            if (key != prev_reg)
            begin
                if (set_reg)
                begin
                    // Set mode: digit entry, copy, switch, leave
                    if (key == KEY_SET)
                    begin
                        set_next  = 1'b0;
                        dcnt_next = DIG_MIN_TENS;
                    end
                    else if (key == KEY_COPY)
                    begin
                        m_new = min_reg[!p];
                        s_new = sec_reg[!p];
                    end
                    else if (key == KEY_SWITCH)
                    begin
                        player_next = !p;
                    end
                    else if (key <= KEY_SEC_DN1)
                    begin
                        case (dcnt_reg)
                            DIG_MIN_TENS:
                            begin
                                entry     = {{(MIN_W-KEY_W){1'b0}}, stg_code_reg};
                                m_new     = (entry > MIN_LIMIT) ? MIN_LIMIT : entry;
                                pend_next = stg_code_reg;
                                dcnt_next = DIG_MIN_UNITS;
                            end
                            DIG_MIN_UNITS:
                            begin
                                entry     = times_ten(pend_reg)
                                          + {{(MIN_W-KEY_W){1'b0}}, stg_code_reg};
                                m_new     = (entry > MIN_LIMIT) ? MIN_LIMIT : entry;
                                pend_next = '0;
                                dcnt_next = DIG_SEC_TENS;
                            end
                            DIG_SEC_TENS:
                            begin
                                entry     = times_ten(stg_code_reg);
                                s_new     = (entry > MIN_W'(SEC_MAX)) ? SEC_MAX
                                                                      : entry[SEC_W-1:0];
                                pend_next = stg_code_reg;
                                dcnt_next = DIG_SEC_UNITS;
                            end
                            default:
                            begin
                                entry     = times_ten(pend_reg)
                                          + {{(MIN_W-KEY_W){1'b0}}, stg_code_reg};
                                s_new     = (entry > MIN_W'(SEC_MAX)) ? SEC_MAX
                                                                      : entry[SEC_W-1:0];
                                dcnt_next = DIG_MIN_TENS;
                                set_next  = 1'b0;
                            end
                        endcase
                    end
                end
                else
                begin
                    // Run mode keys
                    case (key)
                        KEY_SWITCH: player_next = !p;
                        KEY_PAUSE:  pause_next  = !pause_reg;
                        KEY_MIN_UP:
                        begin
                            if (m_cur < MIN_LIMIT) m_new = m_cur + 1'b1;
                        end
                        KEY_MIN_DN:
                        begin
                            if (m_cur != '0) m_new = m_cur - 1'b1;
                        end
                        KEY_SEC_UP10, KEY_SEC_UP1:
                        begin
                            sec_sum = {1'b0, s_cur}
                                    + ((key == KEY_SEC_UP10) ? 7'd10 : 7'd1);
                            if (sec_sum <= MIN_W'(SEC_MAX))
                            begin
                                s_new = sec_sum[SEC_W-1:0];
                            end
                            else if (m_cur < MIN_LIMIT)
                            begin
                                m_new = m_cur + 1'b1;
                                s_new = '0;
                            end
                        end
                        KEY_SEC_DN10, KEY_SEC_DN1:
                        begin
                            if (key == KEY_SEC_DN10 ? (s_cur > 6'd10) : (s_cur > 6'd1))
                            begin
                                s_new = s_cur - ((key == KEY_SEC_DN10) ? 6'd10 : 6'd1);
                            end
                            else if (m_cur != '0)
                            begin
                                m_new = m_cur - 1'b1;
                                s_new = SEC_BORROW;
                            end
                        end
                        KEY_CLR_SEC: s_new = '0;
                        KEY_CLR_MIN: m_new = '0;
                        KEY_SET:
                        begin
                            set_next  = 1'b1;
                            dcnt_next = DIG_MIN_TENS;
                            pend_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
        end

        min_next[p] = m_new;
        sec_next[p] = s_new;
    end

    // Advance the clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg[0] <= MIN_W'(1);
            min_reg[1] <= MIN_W'(1);
            sec_reg[0] <= '0;
            sec_reg[1] <= '0;
            player_reg <= 1'b0;
            pause_reg  <= 1'b0;
            set_reg    <= 1'b0;
            dcnt_reg   <= DIG_MIN_TENS;
            pend_reg   <= '0;
            prev_reg   <= KEY_NONE;
        end
        else if (advance)
        begin
            min_reg    <= min_next;
            sec_reg    <= sec_next;
            player_reg <= player_next;
            pause_reg  <= pause_next;
            set_reg    <= set_next;
            dcnt_reg   <= dcnt_next;
            pend_reg   <= pend_next;
            prev_reg   <= prev_next;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_min_reg    <= min_next[player_next];
            res_sec_reg    <= sec_next[player_next];
            res_player_reg <= player_next;
            res_pause_reg  <= pause_next;
            res_edit_reg   <= set_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign shown_minutes = res_min_reg;
    assign shown_seconds = res_sec_reg;
    assign active_player = res_player_reg;
    assign paused        = res_pause_reg;
    assign editing       = res_edit_reg;

    // Checks
    a_min_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (shown_minutes <= MIN_LIMIT))
        else $error("shown minutes above limit");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (shown_seconds <= SEC_BORROW))
        else $error("shown seconds out of range");

    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("processed item produced no result");

    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !set_reg |-> (dcnt_reg == DIG_MIN_TENS))
        else $error("digit count not cleared outside set mode");

endmodule : two_player_game_clock_unit
`default_nettype wire
